// File: rtl/core/jtok_pkg.sv
// shared types, constants, byte classes and command/status structs of the json tokenizer
package jtok_pkg;

  // literal buffer geometry
  localparam int LITERAL_BYTES = 64;
  localparam int LIT_AW        = $clog2(LITERAL_BYTES);
  localparam int LEN_W         = $clog2(LITERAL_BYTES + 1);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LITERAL_BYTES);

  typedef logic [3:0] kind_t;
  typedef logic [1:0] err_t;
  typedef logic [2:0] mode_t;
  typedef logic [2:0] nstate_t;

  // result kinds
  localparam kind_t KIND_END    = 4'd0;
  localparam kind_t KIND_LBRACE = 4'd1;
  localparam kind_t KIND_RBRACE = 4'd2;
  localparam kind_t KIND_COLON  = 4'd3;
  localparam kind_t KIND_LBRACK = 4'd4;
  localparam kind_t KIND_RBRACK = 4'd5;
  localparam kind_t KIND_COMMA  = 4'd6;
  localparam kind_t KIND_LIT    = 4'd7;
  localparam kind_t KIND_ERR    = 4'd8;

  // error codes
  localparam err_t ERR_NONE    = 2'd0;
  localparam err_t ERR_INVALID = 2'd1;
  localparam err_t ERR_READ    = 2'd2;

  // lexer modes
  localparam mode_t MODE_IDLE   = 3'd0;
  localparam mode_t MODE_WORD   = 3'd1;
  localparam mode_t MODE_STRING = 3'd2;
  localparam mode_t MODE_ESCAPE = 3'd3;
  localparam mode_t MODE_NUMBER = 3'd4;

  // number grammar states
  localparam nstate_t NS_START = 3'd0;
  localparam nstate_t NS_INT   = 3'd1;
  localparam nstate_t NS_ZERO  = 3'd2;
  localparam nstate_t NS_DOT   = 3'd3;
  localparam nstate_t NS_FRAC  = 3'd4;
  localparam nstate_t NS_BAD   = 3'd5;

  // characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  // datapath commands for one cycle
  typedef struct packed {
    logic  latch;     // capture the input beat
    logic  push;      // load the output register
    logic  push_lit;  // pushed result is the next buffered literal byte
    kind_t kind;
    err_t  err;
    logic  store;     // write the current byte into the buffer
    logic  clear;     // drop the buffer (store then lands at entry zero)
    logic  nl_inc;    // count a skipped newline
  } cmd_t;

  // datapath status back to the controller
  typedef struct packed {
    logic [7:0] cur_byte;
    logic       cur_end;
    logic       cur_rf;
    logic       full;
    logic       len_zero;
    logic       lit_last;
    logic       out_free;
  } sts_t;

  // what idle mode does with one item
  typedef struct packed {
    logic    push;
    kind_t   kind;
    err_t    err;
    logic    store;
    logic    clear;
    logic    nl_inc;
    mode_t   mode;
    logic    ns_load;
    nstate_t ns;
  } idle_act_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CH_USCORE);
  endfunction

  function automatic logic is_print(input logic [7:0] b);
    return (b >= 8'h20) && (b <= 8'h7E);
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return (b > 8'h20) && (b < 8'h7F) && !is_alpha(b) && !is_digit(b);
  endfunction

  // number grammar step
  function automatic nstate_t number_next(input nstate_t s, input logic [7:0] b);
    nstate_t n;
    if (b == CH_DOT) begin
      n = ((s == NS_INT) || (s == NS_ZERO)) ? NS_DOT : NS_BAD;
    end else begin
      unique case (s)
        NS_START: n = (b == CH_ZERO) ? NS_ZERO : NS_INT;
        NS_INT:   n = NS_INT;
        NS_DOT:   n = NS_FRAC;
        NS_FRAC:  n = NS_FRAC;
        default:  n = NS_BAD;
      endcase
    end
    return n;
  endfunction

  // idle mode handling of a byte or an end
  function automatic idle_act_t idle_act(input logic [7:0] b, input logic at_end,
                                         input logic rf);
    idle_act_t a;
    a = '0;
    a.kind = KIND_END;
    a.err  = ERR_NONE;
    a.mode = MODE_IDLE;
    a.ns   = NS_START;
    if (at_end) begin
      a.push = 1'b1;
      if (rf) begin
        a.kind = KIND_ERR;
        a.err  = ERR_READ;
      end
    end else begin
      a.clear = 1'b1;
      if (is_space(b)) begin
        a.nl_inc = (b == CH_LF);
      end else if (b == CH_LBRACE) begin
        a.push = 1'b1;
        a.kind = KIND_LBRACE;
      end else if (b == CH_RBRACE) begin
        a.push = 1'b1;
        a.kind = KIND_RBRACE;
      end else if (b == CH_COLON) begin
        a.push = 1'b1;
        a.kind = KIND_COLON;
      end else if (b == CH_LBRACK) begin
        a.push = 1'b1;
        a.kind = KIND_LBRACK;
      end else if (b == CH_RBRACK) begin
        a.push = 1'b1;
        a.kind = KIND_RBRACK;
      end else if (b == CH_COMMA) begin
        a.push = 1'b1;
        a.kind = KIND_COMMA;
      end else if (b == CH_QUOTE) begin
        a.mode = MODE_STRING;
      end else if (is_alpha(b) || (b == CH_USCORE)) begin
        a.mode  = MODE_WORD;
        a.store = 1'b1;
      end else if (is_digit(b)) begin
        a.mode    = MODE_NUMBER;
        a.store   = 1'b1;
        a.ns_load = 1'b1;
        a.ns      = number_next(NS_START, b);
      end else begin
        a.push = 1'b1;
        a.kind = KIND_ERR;
        a.err  = ERR_INVALID;
      end
    end
    return a;
  endfunction

endpackage

// File: rtl/core/jtok_if.sv
// valid/ready channel interfaces for the tokenizer input bytes and result beats
interface jtok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       at_end;
  logic       read_failed;

  modport source (output valid, output data_byte, output at_end, output read_failed,
                  input ready);
  modport sink (input valid, input data_byte, input at_end, input read_failed,
                output ready);
endinterface

interface jtok_out_if;
  logic                valid;
  logic                ready;
  jtok_pkg::kind_t     kind;
  logic [7:0]          char_value;
  logic                char_valid;
  logic                last;
  jtok_pkg::err_t      error_code;
  logic [31:0]         line_count;

  modport source (output valid, output kind, output char_value, output char_valid,
                  output last, output error_code, output line_count, input ready);
  modport sink (input valid, input kind, input char_value, input char_valid,
                input last, input error_code, input line_count, output ready);
endinterface

// File: rtl/core/jtok_dp.sv
// tokenizer datapath: held input beat, literal buffer, newline counter, output register
module jtok_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  jtok_pkg::cmd_t     cmd,
  input  logic               sel_held,
  output jtok_pkg::sts_t     sts,
  input  logic [7:0]         in_byte,
  input  logic               in_end,
  input  logic               in_rf,
  output logic               out_valid,
  input  logic               out_ready,
  output jtok_pkg::kind_t    out_kind,
  output logic [7:0]         out_char,
  output logic               out_char_valid,
  output logic               out_last,
  output jtok_pkg::err_t     out_err,
  output logic [31:0]        out_lines
);

  logic [7:0]                  mem [jtok_pkg::LITERAL_BYTES];
  logic [7:0]                  held_byte_r;
  logic                        held_end_r;
  logic                        held_rf_r;
  logic [jtok_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [jtok_pkg::LIT_AW-1:0] idx_r, idx_nxt;
  logic [jtok_pkg::LIT_AW-1:0] wr_addr;
  logic [7:0]                  rd_data_r;
  logic [31:0]                 total_r, total_nxt;
  logic                        out_valid_r;
  jtok_pkg::kind_t             kind_r;
  logic [7:0]                  char_r;
  logic                        cvalid_r;
  logic                        last_r;
  jtok_pkg::err_t              err_r;
  logic [31:0]                 lines_r;
  logic [7:0]                  cur_byte;
  logic                        lit_last;

  // current item: the live beat, or the one held over a literal burst
  assign cur_byte = sel_held ? held_byte_r : in_byte;
  assign lit_last = ((jtok_pkg::LEN_W'(idx_r) + jtok_pkg::LEN_W'(1)) == len_r);

  always_comb begin
    sts.cur_byte = cur_byte;
    sts.cur_end  = sel_held ? held_end_r : in_end;
    sts.cur_rf   = sel_held ? held_rf_r : in_rf;
    sts.full     = (len_r >= jtok_pkg::LEN_FULL);
    sts.len_zero = (len_r == '0);
    sts.lit_last = lit_last;
    sts.out_free = !out_valid_r || out_ready;
  end

  // buffer length, emit index and newline count
  assign wr_addr = cmd.clear ? '0 : len_r[jtok_pkg::LIT_AW-1:0];

  always_comb begin
    if (cmd.clear) begin
      len_nxt = cmd.store ? jtok_pkg::LEN_W'(1) : '0;
    end else begin
      len_nxt = len_r + jtok_pkg::LEN_W'(cmd.store);
    end
    if (cmd.push_lit) begin
      idx_nxt = lit_last ? '0 : idx_r + jtok_pkg::LIT_AW'(1);
    end else begin
      idx_nxt = idx_r;
    end
    if (cmd.nl_inc && (total_r != '1)) begin
      total_nxt = total_r + 32'd1;
    end else begin
      total_nxt = total_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      idx_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      total_r <= total_nxt;
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // literal buffer, read one entry ahead of the emit index
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[wr_addr] <= cur_byte;
    end
    rd_data_r <= mem[idx_nxt];
  end

  // held beat and output payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      held_byte_r <= in_byte;
      held_end_r  <= in_end;
      held_rf_r   <= in_rf;
    end
    if (cmd.push) begin
      kind_r   <= cmd.kind;
      char_r   <= cmd.push_lit ? rd_data_r : 8'd0;
      cvalid_r <= cmd.push_lit;
      last_r   <= cmd.push_lit ? lit_last : 1'b1;
      err_r    <= cmd.err;
      lines_r  <= total_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_char       = char_r;
  assign out_char_valid = cvalid_r;
  assign out_last       = last_r;
  assign out_err        = err_r;
  assign out_lines      = lines_r;

endmodule

// File: rtl/core/jtok_ctrl.sv
// tokenizer controller: lexer mode, number grammar and accept/emit sequencing
module jtok_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  jtok_pkg::sts_t sts,
  output jtok_pkg::cmd_t cmd,
  output logic           sel_held
);

  localparam logic [1:0] PH_RUN  = 2'd0;
  localparam logic [1:0] PH_EMIT = 2'd1;
  localparam logic [1:0] PH_PEND = 2'd2;

  logic [1:0]          phase_r, phase_nxt;
  jtok_pkg::mode_t     mode_r, mode_nxt;
  jtok_pkg::nstate_t   ns_r, ns_nxt;
  logic                pend_r, pend_nxt;
  jtok_pkg::idle_act_t ia;
  jtok_pkg::nstate_t   ns_step;
  logic [7:0]          b;
  logic                fail_en;
  jtok_pkg::err_t      fail_code;
  logic                take_idle;
  logic                go_emit;
  logic                go_pend;
  logic                num_done_ok;

  assign sel_held = (phase_r == PH_PEND);
  assign b        = sts.cur_byte;
  assign ia       = jtok_pkg::idle_act(b, sts.cur_end, sts.cur_rf);
  assign ns_step  = jtok_pkg::number_next(ns_r, b);

  // a number may close only in a complete state, not full, on end, space or punctuation
  assign num_done_ok = ((ns_r == jtok_pkg::NS_INT) || (ns_r == jtok_pkg::NS_ZERO) ||
                        (ns_r == jtok_pkg::NS_FRAC)) &&
                       (sts.cur_end || jtok_pkg::is_space(b) || jtok_pkg::is_punct(b)) &&
                       !sts.full;

  // next state and commands
  always_comb begin
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    ns_nxt    = ns_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    cmd.kind  = jtok_pkg::KIND_END;
    cmd.err   = jtok_pkg::ERR_NONE;
    in_ready  = 1'b0;
    fail_en   = 1'b0;
    fail_code = jtok_pkg::ERR_INVALID;
    take_idle = 1'b0;
    go_emit   = 1'b0;
    go_pend   = 1'b0;

    unique case (phase_r)
      PH_RUN: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.latch = 1'b1;
          unique case (mode_r)
            jtok_pkg::MODE_WORD: begin
              if (sts.full) begin
                fail_en = 1'b1;
              end else if (!sts.cur_end && jtok_pkg::is_word(b)) begin
                cmd.store = 1'b1;
              end else begin
                go_emit = 1'b1;
                go_pend = 1'b1;
              end
            end
            jtok_pkg::MODE_STRING: begin
              if (sts.cur_end) begin
                fail_en   = 1'b1;
                fail_code = sts.cur_rf ? jtok_pkg::ERR_READ : jtok_pkg::ERR_INVALID;
              end else if (b == jtok_pkg::CH_QUOTE) begin
                if (sts.full) begin
                  fail_en = 1'b1;
                end else if (sts.len_zero) begin
                  // empty string: one literal beat with no byte
                  cmd.push  = 1'b1;
                  cmd.kind  = jtok_pkg::KIND_LIT;
                  cmd.clear = 1'b1;
                  mode_nxt  = jtok_pkg::MODE_IDLE;
                end else begin
                  go_emit = 1'b1;
                end
              end else if (b == jtok_pkg::CH_BSLASH) begin
                mode_nxt = jtok_pkg::MODE_ESCAPE;
              end else if (!jtok_pkg::is_print(b) || sts.full) begin
                fail_en = 1'b1;
              end else begin
                cmd.store = 1'b1;
              end
            end
            jtok_pkg::MODE_ESCAPE: begin
              if (sts.cur_end) begin
                fail_en   = 1'b1;
                fail_code = sts.cur_rf ? jtok_pkg::ERR_READ : jtok_pkg::ERR_INVALID;
              end else if (!jtok_pkg::is_print(b) || sts.full) begin
                fail_en = 1'b1;
              end else begin
                cmd.store = 1'b1;
                mode_nxt  = jtok_pkg::MODE_STRING;
              end
            end
            jtok_pkg::MODE_NUMBER: begin
              if (!sts.cur_end && (jtok_pkg::is_digit(b) || (b == jtok_pkg::CH_DOT))) begin
                if ((ns_step == jtok_pkg::NS_BAD) || sts.full) begin
                  fail_en = 1'b1;
                end else begin
                  cmd.store = 1'b1;
                  ns_nxt    = ns_step;
                end
              end else if (!num_done_ok) begin
                fail_en = 1'b1;
              end else begin
                go_emit = 1'b1;
                go_pend = 1'b1;
              end
            end
            default: begin
              take_idle = 1'b1;
            end
          endcase
        end
      end
      PH_EMIT: begin
        // stream buffered bytes, one beat per free output slot
        if (sts.out_free) begin
          cmd.push     = 1'b1;
          cmd.push_lit = 1'b1;
          cmd.kind     = jtok_pkg::KIND_LIT;
          if (sts.lit_last) begin
            cmd.clear = 1'b1;
            phase_nxt = pend_r ? PH_PEND : PH_RUN;
            pend_nxt  = 1'b0;
          end
        end
      end
      PH_PEND: begin
        // the beat that closed a word or number, taken again in idle mode
        if (sts.out_free) begin
          take_idle = 1'b1;
          phase_nxt = PH_RUN;
        end
      end
      default: begin
        phase_nxt = PH_RUN;
      end
    endcase

    // an error drops the literal and returns to idle
    if (fail_en) begin
      cmd.push  = 1'b1;
      cmd.kind  = jtok_pkg::KIND_ERR;
      cmd.err   = fail_code;
      cmd.clear = 1'b1;
      mode_nxt  = jtok_pkg::MODE_IDLE;
    end

    if (go_emit) begin
      phase_nxt = PH_EMIT;
      pend_nxt  = go_pend;
      mode_nxt  = jtok_pkg::MODE_IDLE;
    end

    if (take_idle) begin
      cmd.push   = ia.push;
      cmd.kind   = ia.kind;
      cmd.err    = ia.err;
      cmd.store  = ia.store;
      cmd.clear  = ia.clear;
      cmd.nl_inc = ia.nl_inc;
      mode_nxt   = ia.mode;
      if (ia.ns_load) begin
        ns_nxt = ia.ns;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RUN;
      mode_r  <= jtok_pkg::MODE_IDLE;
      ns_r    <= jtok_pkg::NS_START;
      pend_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      mode_r  <= mode_nxt;
      ns_r    <= ns_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

// File: rtl/core/json_tokenizer_core.sv
// json tokenizer top level: controller, datapath and channel hookup
// An error, punctuation or end beat closing no literal shows in the cycle after its input.
// Throughput: one input byte per cycle while no literal goes out and the output is not stalled.
// A literal of n bytes is sent as n beats, one per free output cycle, from the buffer read
// port after its closing byte; a byte that ends a word or number is then retaken in idle mode.
// Reset (synchronous, active low) clears mode, number state, length, line count and output
// valid; the literal buffer is not cleared, only entries written since are ever read.
module json_tokenizer_core (
  input  logic       clk,
  input  logic       rst_n,
  jtok_in_if.sink    in_ch,
  jtok_out_if.source out_ch
);

  jtok_pkg::cmd_t cmd;
  jtok_pkg::sts_t sts;
  logic           sel_held;

  jtok_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd),
    .sel_held (sel_held)
  );

  jtok_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sel_held       (sel_held),
    .sts            (sts),
    .in_byte        (in_ch.data_byte),
    .in_end         (in_ch.at_end),
    .in_rf          (in_ch.read_failed),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_kind       (out_ch.kind),
    .out_char       (out_ch.char_value),
    .out_char_valid (out_ch.char_valid),
    .out_last       (out_ch.last),
    .out_err        (out_ch.error_code),
    .out_lines      (out_ch.line_count)
  );

`ifndef NO_ASSERTIONS
  // a beat carrying a byte must be a literal beat
  a_char_is_lit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.char_valid |-> out_ch.kind == jtok_pkg::KIND_LIT)
    else $error("char_valid on a non-literal beat");

  // only literal beats can be non-final
  a_nonlit_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.kind != jtok_pkg::KIND_LIT) |-> out_ch.last)
    else $error("non-literal beat without last");

  // error beats always carry a code
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.kind == jtok_pkg::KIND_ERR) |->
      out_ch.error_code != jtok_pkg::ERR_NONE)
    else $error("error beat without a code");

  // the buffer is empty after its final literal beat goes out
  a_buf_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_lit && sts.lit_last |=> sts.len_zero)
    else $error("literal buffer not dropped after its last beat");

  // no input beat is taken while a literal burst is in flight
  a_no_accept_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_lit |-> !in_ch.ready)
    else $error("input accepted during literal burst");
`endif

endmodule

// File: tb/sv/json_tokenizer_core_tb.sv
// self-checking testbench for the json tokenizer core with a built-in token predictor
`timescale 1ns / 1ps

module json_tokenizer_core_tb;
  import jtok_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE_LAT   = 8;
  localparam int MAX_PRINTS   = 40;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // one expected result beat
  typedef struct {
    kind_t       kind;
    logic [7:0]  char_value;
    logic        char_valid;
    logic        last;
    err_t        error_code;
    logic [31:0] line_count;
  } token_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  jtok_in_if  in_ch ();
  jtok_out_if out_ch ();

  json_tokenizer_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  mode_t       scan_mode;
  nstate_t     num_phase;
  logic [7:0]  held_bytes [LITERAL_BYTES];
  int          held_count;
  logic [31:0] lines_seen;
  int          step_beats;

  token_beat_t pending_tokens [$];
  int          mismatch_count;
  int          sent_items;
  int          got_beats;
  int          quiet_cycles;
  int          send_gap_pct;
  int          recv_stall_pct;

  // byte classes
  function automatic logic digit_b(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic letter_b(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic blank_b(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic printable_b(input logic [7:0] b);
    return (b >= CH_SPACE) && (b <= CH_TILDE);
  endfunction

  function automatic logic punctch_b(input logic [7:0] b);
    return (b > CH_SPACE) && (b < CH_DEL) && !letter_b(b) && !digit_b(b);
  endfunction

  // queue one expected beat, at most one buffer's worth per input item
  function automatic void push_beat(input kind_t k, input logic [7:0] c, input logic v,
                                    input logic l, input err_t e);
    token_beat_t t;
    if (step_beats >= LITERAL_BYTES) return;
    t.kind       = k;
    t.char_value = c;
    t.char_valid = v;
    t.last       = l;
    t.error_code = e;
    t.line_count = lines_seen;
    pending_tokens.push_back(t);
    step_beats++;
  endfunction

  function automatic void raise_error(input err_t code);
    push_beat(KIND_ERR, 8'h00, 1'b0, 1'b1, code);
    scan_mode  = MODE_IDLE;
    held_count = 0;
  endfunction

  function automatic void flush_literal();
    if (held_count == 0) begin
      push_beat(KIND_LIT, 8'h00, 1'b0, 1'b1, ERR_NONE);
    end else begin
      for (int i = 0; i < held_count; i++)
        push_beat(KIND_LIT, held_bytes[i], 1'b1, (i + 1 == held_count), ERR_NONE);
    end
    scan_mode  = MODE_IDLE;
    held_count = 0;
  endfunction

  function automatic logic keep_byte(input logic [7:0] b);
    if (held_count >= LITERAL_BYTES) return 1'b0;
    held_bytes[held_count] = b;
    held_count++;
    return 1'b1;
  endfunction

  // number grammar: digits, or digits dot digits, no leading zero
  function automatic nstate_t grammar_step(input nstate_t s, input logic [7:0] b);
    if (b == CH_DOT) return ((s == NS_INT) || (s == NS_ZERO)) ? NS_DOT : NS_BAD;
    case (s)
      NS_START: return (b == CH_ZERO) ? NS_ZERO : NS_INT;
      NS_INT:   return NS_INT;
      NS_DOT:   return NS_FRAC;
      NS_FRAC:  return NS_FRAC;
      default:  return NS_BAD;
    endcase
  endfunction

  function automatic void idle_finish(input logic rf);
    if (rf) push_beat(KIND_ERR, 8'h00, 1'b0, 1'b1, ERR_READ);
    else push_beat(KIND_END, 8'h00, 1'b0, 1'b1, ERR_NONE);
  endfunction

  function automatic void idle_take(input logic [7:0] b);
    scan_mode  = MODE_IDLE;
    held_count = 0;
    if (blank_b(b)) begin
      if ((b == CH_LF) && (lines_seen != '1)) lines_seen++;
      return;
    end
    case (b)
      CH_LBRACE: push_beat(KIND_LBRACE, 8'h00, 1'b0, 1'b1, ERR_NONE);
      CH_RBRACE: push_beat(KIND_RBRACE, 8'h00, 1'b0, 1'b1, ERR_NONE);
      CH_COLON:  push_beat(KIND_COLON, 8'h00, 1'b0, 1'b1, ERR_NONE);
      CH_LBRACK: push_beat(KIND_LBRACK, 8'h00, 1'b0, 1'b1, ERR_NONE);
      CH_RBRACK: push_beat(KIND_RBRACK, 8'h00, 1'b0, 1'b1, ERR_NONE);
      CH_COMMA:  push_beat(KIND_COMMA, 8'h00, 1'b0, 1'b1, ERR_NONE);
      CH_QUOTE:  scan_mode = MODE_STRING;
      default: begin
        if (letter_b(b) || (b == CH_USCORE)) begin
          scan_mode = MODE_WORD;
          void'(keep_byte(b));
        end else if (digit_b(b)) begin
          scan_mode = MODE_NUMBER;
          num_phase = grammar_step(NS_START, b);
          void'(keep_byte(b));
        end else begin
          raise_error(ERR_INVALID);
        end
      end
    endcase
  endfunction

  function automatic void string_take(input logic [7:0] b);
    scan_mode = MODE_STRING;
    if (!printable_b(b)) raise_error(ERR_INVALID);
    else if (!keep_byte(b)) raise_error(ERR_INVALID);
  endfunction

  // expected beats for one accepted input item
  function automatic void predict_tokens(input logic [7:0] b, input logic e, input logic rf);
    nstate_t ns;
    logic    good_end;
    step_beats = 0;
    case (scan_mode)
      MODE_WORD: begin
        if (held_count >= LITERAL_BYTES) begin
          raise_error(ERR_INVALID);
        end else if (!e && (letter_b(b) || digit_b(b) || (b == CH_USCORE))) begin
          void'(keep_byte(b));
        end else begin
          flush_literal();
          if (e) idle_finish(rf);
          else idle_take(b);
        end
      end
      MODE_STRING: begin
        if (e) raise_error(rf ? ERR_READ : ERR_INVALID);
        else if (b == CH_QUOTE) begin
          if (held_count >= LITERAL_BYTES) raise_error(ERR_INVALID);
          else flush_literal();
        end else if (b == CH_BSLASH) scan_mode = MODE_ESCAPE;
        else string_take(b);
      end
      MODE_ESCAPE: begin
        if (e) raise_error(rf ? ERR_READ : ERR_INVALID);
        else string_take(b);
      end
      MODE_NUMBER: begin
        if (!e && (digit_b(b) || (b == CH_DOT))) begin
          ns = grammar_step(num_phase, b);
          if (ns == NS_BAD) raise_error(ERR_INVALID);
          else if (!keep_byte(b)) raise_error(ERR_INVALID);
          else num_phase = ns;
        end else begin
          good_end = ((num_phase == NS_INT) || (num_phase == NS_ZERO) ||
                      (num_phase == NS_FRAC)) &&
                     (e || blank_b(b) || punctch_b(b)) && (held_count < LITERAL_BYTES);
          if (!good_end) begin
            raise_error(ERR_INVALID);
          end else begin
            flush_literal();
            if (e) idle_finish(rf);
            else idle_take(b);
          end
        end
      end
      default: begin
        if (e) idle_finish(rf);
        else idle_take(b);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t: result beat %0d, %s: got 0x%0h, expected 0x%0h",
               $time, got_beats, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_token_beat();
    token_beat_t want;
    if (pending_tokens.size() == 0) begin
      report_mismatch("beat with nothing pending, kind", 32'(out_ch.kind), 32'(KIND_END));
      return;
    end
    want = pending_tokens.pop_front();
    if (out_ch.kind !== want.kind)
      report_mismatch("kind", 32'(out_ch.kind), 32'(want.kind));
    if (out_ch.char_value !== want.char_value)
      report_mismatch("char_value", 32'(out_ch.char_value), 32'(want.char_value));
    if (out_ch.char_valid !== want.char_valid)
      report_mismatch("char_valid", 32'(out_ch.char_valid), 32'(want.char_valid));
    if (out_ch.last !== want.last)
      report_mismatch("last", 32'(out_ch.last), 32'(want.last));
    if (out_ch.error_code !== want.error_code)
      report_mismatch("error_code", 32'(out_ch.error_code), 32'(want.error_code));
    if (out_ch.line_count !== want.line_count)
      report_mismatch("line_count", out_ch.line_count, want.line_count);
  endtask

  // result side: check each beat, stall at random
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      check_token_beat();
      got_beats++;
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles where neither side moves a beat
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // send one input beat, idling at random before it
  task automatic send_beat(input logic [7:0] b, input logic e, input logic rf);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.at_end      <= e;
    in_ch.read_failed <= rf;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_tokens(b, e, rf);
    sent_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0, 1'b0);
  endtask

  task automatic send_end(input logic rf);
    send_beat(8'($urandom_range(255)), 1'b1, rf);
  endtask

  // hold off until every expected beat has come out
  task automatic wait_all_tokens();
    in_ch.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_LAT) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_word_byte(input logic head);
    int r;
    r = $urandom_range(head ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return CH_USCORE;
    return 8'(CH_ZERO + r - 53);
  endfunction

  function automatic logic [7:0] pick_punct();
    case ($urandom_range(5))
      0:       return CH_LBRACE;
      1:       return CH_RBRACE;
      2:       return CH_COLON;
      3:       return CH_LBRACK;
      4:       return CH_RBRACK;
      default: return CH_COMMA;
    endcase
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(6))
      0:       return CH_TAB;
      1:       return CH_VT;
      2:       return CH_FF;
      3:       return CH_CR;
      4, 5:    return CH_LF;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic int pick_size();
    return ($urandom_range(99) < 3) ? $urandom_range(60, LITERAL_BYTES) : $urandom_range(8);
  endfunction

  task automatic send_word(input int n);
    send_beat(pick_word_byte(1'b1), 1'b0, 1'b0);
    for (int i = 1; i < n; i++) send_beat(pick_word_byte(1'b0), 1'b0, 1'b0);
  endtask

  // quoted string holding n bytes, quote and backslash always escaped
  task automatic send_string(input int n, input logic close);
    logic [7:0] c;
    send_beat(CH_QUOTE, 1'b0, 1'b0);
    for (int i = 0; i < n; i++) begin
      c = 8'($urandom_range(CH_SPACE, CH_TILDE));
      if ((c == CH_QUOTE) || (c == CH_BSLASH) || ($urandom_range(19) == 0))
        send_beat(CH_BSLASH, 1'b0, 1'b0);
      send_beat(c, 1'b0, 1'b0);
    end
    if (close) send_beat(CH_QUOTE, 1'b0, 1'b0);
  endtask

  // n_int integer digits (no leading zero unless alone), then an optional fraction
  task automatic send_number(input int n_int, input int n_frac);
    if (n_int == 1) send_beat(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b0, 1'b0);
    else send_beat(8'($urandom_range(CH_ZERO + 1, CH_NINE)), 1'b0, 1'b0);
    for (int i = 1; i < n_int; i++) send_beat(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b0, 1'b0);
    if (n_frac > 0) begin
      send_beat(CH_DOT, 1'b0, 1'b0);
      repeat (n_frac) send_beat(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b0, 1'b0);
    end
  endtask

  task automatic send_separator();
    case ($urandom_range(9))
      0, 1, 2: send_beat(pick_space(), 1'b0, 1'b0);
      9:       send_end(1'($urandom_range(1)));
      default: send_beat(pick_punct(), 1'b0, 1'b0);
    endcase
  endtask

  // malformed input of several sorts
  task automatic send_noise();
    logic [7:0] bad;
    bad = $urandom_range(1) ? 8'($urandom_range(CH_SPACE - 1)) : 8'($urandom_range(CH_DEL, 255));
    case ($urandom_range(4))
      0: send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      1: begin
        send_string($urandom_range(3), 1'b0);
        if ($urandom_range(1)) send_beat(CH_BSLASH, 1'b0, 1'b0);
        send_beat(bad, 1'b0, 1'b0);
      end
      2: begin
        send_number($urandom_range(1, 3), $urandom_range(1) ? 0 : $urandom_range(1, 2));
        send_beat(pick_word_byte(1'b1), 1'b0, 1'b0);
      end
      3: begin
        case ($urandom_range(2))
          0: send_text("07");
          1: send_text("3..");
          default: begin
            send_text("5.");
            send_separator();
          end
        endcase
      end
      default: begin
        send_string($urandom_range(3), 1'b0);
        if ($urandom_range(1)) send_beat(CH_BSLASH, 1'b0, 1'b0);
        send_end(1'($urandom_range(1)));
      end
    endcase
  endtask

  // every punctuation token and every whitespace byte, newlines counted
  task automatic test_punct_and_space();
    send_text("{\t}\n:");
    send_beat(CH_CR, 1'b0, 1'b0);
    send_text("[ ],");
    send_beat(CH_VT, 1'b0, 1'b0);
    send_beat(CH_FF, 1'b0, 1'b0);
    send_beat(CH_LF, 1'b0, 1'b0);
    wait_all_tokens();
  endtask

  // words, numbers, escaped and empty strings
  task automatic test_literals();
    send_text("_aZ9 0,12.50]\"\\\"~\"\"\" ");
    wait_all_tokens();
  endtask

  // bad idle bytes, broken numbers, bad string bytes
  task automatic test_bad_input();
    send_beat(8'hFF, 1'b0, 1'b0);
    send_text("01 1. 1a.\"");
    send_beat(8'h1F, 1'b0, 1'b0);
    send_text("\"\\");
    send_beat(CH_DEL, 1'b0, 1'b0);
    wait_all_tokens();
  endtask

  // end of input in every mode, with and without a read failure
  task automatic test_end_cases();
    send_end(1'b0);
    send_end(1'b1);
    send_text("\"");
    send_end(1'b1);
    send_text("\"\\");
    send_end(1'b0);
    send_text("7");
    send_end(1'b0);
    send_text("x");
    send_end(1'b1);
    wait_all_tokens();
  endtask

  // literals at and just past the buffer capacity
  task automatic test_buffer_limits();
    send_word(LITERAL_BYTES);
    send_end(1'b1);
    send_string(LITERAL_BYTES - 1, 1'b1);
    send_number(LITERAL_BYTES, 0);
    send_beat(CH_SPACE, 1'b0, 1'b0);
    wait_all_tokens();
  endtask

  // mostly well-formed json fragments with random content, some noise
  task automatic test_random_stream(input int n_items);
    int stop_at;
    int pick;
    int n;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 14) begin
        send_beat(pick_punct(), 1'b0, 1'b0);
      end else if (pick < 26) begin
        send_beat(pick_space(), 1'b0, 1'b0);
      end else if (pick < 42) begin
        n = pick_size();
        send_word((n < 1) ? 1 : n);
        send_separator();
      end else if (pick < 58) begin
        send_string(pick_size(), 1'b1);
      end else if (pick < 74) begin
        if ($urandom_range(99) < 3) send_number($urandom_range(60, LITERAL_BYTES - 1), 0);
        else send_number($urandom_range(1, 4), $urandom_range(1) ? 0 : $urandom_range(1, 3));
        send_separator();
      end else if (pick < 80) begin
        send_end(1'($urandom_range(1)));
      end else begin
        send_noise();
      end
    end
    wait_all_tokens();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = 8'h00;
    in_ch.at_end      = 1'b0;
    in_ch.read_failed = 1'b0;
    out_ch.ready      = 1'b0;
    scan_mode         = MODE_IDLE;
    num_phase         = NS_START;
    held_count        = 0;
    lines_seen        = '0;
    mismatch_count    = 0;
    sent_items        = 0;
    got_beats         = 0;
    quiet_cycles      = 0;
    send_gap_pct      = 9;
    recv_stall_pct    = 63;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_punct_and_space();
    test_literals();
    test_bad_input();
    test_end_cases();
    test_buffer_limits();
    test_random_stream(12);
    send_gap_pct   = 63;
    recv_stall_pct = 9;
    test_random_stream(12);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_stream(12);

    // let any stray beat show up before the verdict
    repeat (4 * SETTLE_LAT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
